// ===== design/cdq_pkg.sv =====
`default_nettype none

package cdq_pkg;

  localparam int DEPTH = 256;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WORD_W = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    FN_PUSH_FRONT = 2'd0,
    FN_PUSH_BACK  = 2'd1,
    FN_POP_FRONT  = 2'd2,
    FN_POP_BACK   = 2'd3
  } func_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  localparam idx_t IDX_LAST = idx_t'(DEPTH - 1);

  function automatic idx_t step_up(input idx_t i);
    return (i == IDX_LAST) ? '0 : idx_t'(i + idx_t'(1));
  endfunction

  function automatic idx_t step_down(input idx_t i);
    return (i == '0) ? IDX_LAST : idx_t'(i - idx_t'(1));
  endfunction

endpackage

`default_nettype wire

// ===== design/circular_deque_core.sv =====
// channel | handshake            | beat fields
// --------+----------------------+------------------
// in      | in_valid / in_stall  | func, push_value
// out     | out_valid / out_stall| pop_value, status
//
// One beat in gives one beat out on the following cycle.
// Sustained rate is one operation per cycle while out_stall is low. The store
// is single-port with one access per beat; its registered read feeds pop_value.
// Reset clears both indices to the last slot; the store itself is not cleared.
// While a result is stalled on the output, in_stall stays high.

`default_nettype none

module circular_deque_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         func,
  input  wire logic signed [31:0] push_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      pop_value,
  output logic [1:0]              status
);

  logic exec;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .exec      (exec)
  );

  cdq_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .exec       (exec),
    .func       (func),
    .push_value (push_value),
    .pop_value  (pop_value),
    .status     (status)
  );

endmodule

`default_nettype wire

// ===== design/cdq_ctrl.sv =====
`default_nettype none

module cdq_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic      exec
);

  cdq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cdq_pkg::S_IDLE: begin
        if (in_valid) state_next = cdq_pkg::S_RESP;
      end
      cdq_pkg::S_RESP: begin
        if (!out_stall && !in_valid) state_next = cdq_pkg::S_IDLE;
      end
      default: state_next = cdq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      cdq_pkg::S_IDLE: begin
        out_valid = 1'b0;
        in_stall  = 1'b0;
      end
      cdq_pkg::S_RESP: begin
        out_valid = 1'b1;
        in_stall  = out_stall;
      end
      default: begin
        out_valid = 1'b0;
        in_stall  = 1'b1;
      end
    endcase
    exec = in_valid && !in_stall;
  end

endmodule

`default_nettype wire

// ===== design/cdq_datapath.sv =====
`default_nettype none

module cdq_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               exec,
  input  wire logic [1:0]         func,
  input  wire logic signed [31:0] push_value,
  output logic signed [31:0]      pop_value,
  output logic [1:0]              status
);

  cdq_pkg::word_t mem [cdq_pkg::DEPTH];

  cdq_pkg::idx_t  head, head_next;
  cdq_pkg::idx_t  tail, tail_next;
  cdq_pkg::idx_t  addr;
  cdq_pkg::idx_t  head_up, head_dn, tail_up, tail_dn;
  cdq_pkg::word_t rdata;
  logic           wr_en;
  logic           pop_ok, pop_ok_next;
  logic [1:0]     status_next;
  logic           empty;

  assign head_up = cdq_pkg::step_up(head);
  assign head_dn = cdq_pkg::step_down(head);
  assign tail_up = cdq_pkg::step_up(tail);
  assign tail_dn = cdq_pkg::step_down(tail);
  assign empty   = (head == tail);

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    addr        = head;
    wr_en       = 1'b0;
    pop_ok_next = 1'b0;
    status_next = cdq_pkg::ST_OK;
    case (cdq_pkg::func_t'(func))
      cdq_pkg::FN_PUSH_FRONT: begin
        addr = head;
        if (head_dn == tail) begin
          status_next = cdq_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          head_next = head_dn;
        end
      end
      cdq_pkg::FN_PUSH_BACK: begin
        addr = tail_up;
        if (tail_up == head) begin
          status_next = cdq_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          tail_next = tail_up;
        end
      end
      cdq_pkg::FN_POP_FRONT: begin
        addr = head_up;
        if (empty) begin
          status_next = cdq_pkg::ST_EMPTY;
        end else begin
          pop_ok_next = 1'b1;
          head_next   = head_up;
        end
      end
      default: begin
        addr = tail;
        if (empty) begin
          status_next = cdq_pkg::ST_EMPTY;
        end else begin
          pop_ok_next = 1'b1;
          tail_next   = tail_dn;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= cdq_pkg::IDX_LAST;
      tail <= cdq_pkg::IDX_LAST;
    end else if (exec) begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      pop_ok <= pop_ok_next;
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      if (wr_en) begin
        mem[addr] <= $unsigned(push_value);
      end
      rdata <= mem[addr];
    end
  end

  assign pop_value = pop_ok ? $signed(rdata) : 32'sd0;

endmodule

`default_nettype wire

// ===== design/cdq_checker.sv =====
`default_nettype none

module cdq_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] pop_value,
  input wire logic [1:0]         status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_beat_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted beat produced no result");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result stalled");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("idle block stalls input");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == cdq_pkg::ST_FULL || status == cdq_pkg::ST_EMPTY)
      |-> pop_value == 32'sd0)
    else $error("rejected beat carries nonzero value");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .pop_value (pop_value),
  .status    (status)
);

`default_nettype wire
